### src/gn3_pkg.sv
// gn3_pkg: shared types, constants and small table functions for the
// fractal gradient noise block; no dependencies
`default_nettype none

package gn3_pkg;

	localparam int NW        = 20;
	localparam int FADE_W    = 17;
	localparam int FRAC_W    = 16;
	localparam int Q_SHIFT   = 12;
	localparam int MIX_SHIFT = 33;
	localparam int KEY_SH_X  = 42;
	localparam int KEY_SH_Y  = 21;
	localparam int CORNERS   = 8;

	localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam logic [31:0] AMP_INIT  = 32'd65536;

	typedef enum logic [2:0] {
		REG_OCTAVE_COUNT,
		REG_BASE_FREQ,
		REG_PERSISTENCE,
		REG_LACUNARITY,
		REG_OUT_SCALE,
		REG_OUT_OFFSET,
		REG_SEED
	} gn3_reg_t;

	typedef struct packed {
		logic [3:0]         octaves;
		logic [15:0]        base_freq;
		logic [15:0]        persistence;
		logic [15:0]        lacunarity;
		logic signed [31:0] scale;
		logic signed [31:0] offset;
		logic [31:0]        seed;
	} gn3_cfg_t;

	typedef struct packed {
		logic        first;
		logic        last;
		logic        none;
		logic [31:0] amp;
	} gn3_tag_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [31:0]        freq;
		logic [31:0]        seed;
		gn3_tag_t           tag;
	} gn3_job_t;

	typedef struct packed {
		logic                 valid;
		logic signed [NW-1:0] noise;
		gn3_tag_t             tag;
	} gn3_oct_t;

	// v mod 12 for an 8-bit value through a reciprocal multiply
	function automatic logic [3:0] mod12(input logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd171;
		q = p[15:11];
		r = v - 8'(q) * 8'd12;
		return r[3:0];
	endfunction

	// dot product of the edge gradient chosen by index g (0 to 11) with a corner offset
	function automatic logic signed [NW-1:0] grad_dot(
		input logic [3:0]         g,
		input logic signed [17:0] dx,
		input logic signed [17:0] dy,
		input logic signed [17:0] dz
	);
		logic signed [NW-1:0] ex;
		logic signed [NW-1:0] ey;
		logic signed [NW-1:0] ez;
		logic signed [NW-1:0] r;
		ex = NW'(dx);
		ey = NW'(dy);
		ez = NW'(dz);
		case (g)
			4'd0:    r = ex + ey;
			4'd1:    r = ey - ex;
			4'd2:    r = ex - ey;
			4'd3:    r = -ex - ey;
			4'd4:    r = ex + ez;
			4'd5:    r = ez - ex;
			4'd6:    r = ex - ez;
			4'd7:    r = -ex - ez;
			4'd8:    r = ey + ez;
			4'd9:    r = ez - ey;
			4'd10:   r = ey - ez;
			4'd11:   r = -ey - ez;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### src/gn3_issue.sv
// gn3_issue: holds one accepted point and issues its octaves, one per cycle while en is high,
// with running frequency, amplitude and seed; uses gn3_pkg
`default_nettype none

module gn3_issue #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire gn3_pkg::gn3_cfg_t cfg,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire signed [31:0]    coord_x,
	input  wire signed [31:0]    coord_y,
	input  wire signed [31:0]    coord_z,
	output gn3_pkg::gn3_job_t    job
);

	localparam int OCW = $clog2(MAX_OCTAVES + 1);

	logic               busy_q;
	logic [OCW-1:0]     oct_q;
	logic [OCW-1:0]     cnt_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [31:0]        freq_q, amp_q, seed_q;

	logic [OCW-1:0] cnt_c;
	logic           last_c;
	logic           accept;
	logic [47:0]    fprod, aprod;
	logic [31:0]    freq_nx, amp_nx;

	always_comb begin
		if (32'(cfg.octaves) > MAX_OCTAVES) begin
			cnt_c = OCW'(MAX_OCTAVES);
		end else begin
			cnt_c = OCW'(cfg.octaves);
		end
	end

	assign last_c   = (cnt_q == '0) || (OCW'(oct_q + 1'b1) == cnt_q);
	assign in_stall = !en || (busy_q && !last_c);
	assign accept   = in_valid && !in_stall;

	assign fprod = 48'(freq_q) * 48'(cfg.lacunarity);
	assign aprod = 48'(amp_q) * 48'(cfg.persistence);

	always_comb begin
		if (|fprod[47:44]) begin
			freq_nx = '1;
		end else begin
			freq_nx = fprod[43:12];
		end
		if (|aprod[47:44]) begin
			amp_nx = '1;
		end else begin
			amp_nx = aprod[43:12];
		end
	end

	always_comb begin
		job.valid     = busy_q;
		job.cx        = cx_q;
		job.cy        = cy_q;
		job.cz        = cz_q;
		job.freq      = freq_q;
		job.seed      = seed_q;
		job.tag.first = (oct_q == '0);
		job.tag.last  = last_c;
		job.tag.none  = (cnt_q == '0);
		job.tag.amp   = amp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (en) begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q && last_c) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (accept) begin
				oct_q  <= '0;
				cnt_q  <= cnt_c;
				cx_q   <= coord_x;
				cy_q   <= coord_y;
				cz_q   <= coord_z;
				freq_q <= 32'(cfg.base_freq);
				amp_q  <= gn3_pkg::AMP_INIT;
				seed_q <= cfg.seed;
			end else if (busy_q) begin
				oct_q  <= OCW'(oct_q + 1'b1);
				freq_q <= freq_nx;
				amp_q  <= amp_nx;
				seed_q <= seed_q + 32'd1;
			end
		end
	end

endmodule

`default_nettype wire

### src/gn3_octave.sv
// gn3_octave: ten-stage pipeline computing one octave of gradient noise
// (scaling, corner hash, fade weights, trilinear blend); uses gn3_pkg
`default_nettype none

module gn3_octave (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire gn3_pkg::gn3_job_t job,
	output gn3_pkg::gn3_oct_t  res
);

	localparam int NW  = gn3_pkg::NW;
	localparam int FW  = gn3_pkg::FADE_W;
	localparam int NC  = gn3_pkg::CORNERS;
	localparam int LPW = NW + 1 + FW + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	gn3_pkg::gn3_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	gn3_pkg::gn3_tag_t tag_s6, tag_s7, tag_s8, tag_s9, tag_s10;

	logic [31:0] seed_s1;
	logic [47:0] pp_s1 [3];

	logic [63:0] x1_s2 [NC];
	logic [15:0] f_s2  [3];
	logic [31:0] f2_s2 [3];

	logic [63:0] pll_s3 [NC];
	logic [31:0] ph_s3  [NC];
	logic [15:0] f_s3   [3];
	logic [47:0] f3_s3  [3];
	logic [19:0] i16_s3 [3];

	logic [63:0] x2_s4  [NC];
	logic [15:0] f_s4   [3];
	logic [51:0] raw_s4 [3];

	logic [63:0] pll_s5 [NC];
	logic [31:0] ph_s5  [NC];
	logic [15:0] f_s5   [3];
	logic [FW-1:0] w_s5 [3];

	logic signed [NW-1:0] n_s6 [NC];
	logic [FW-1:0]        w_s6 [3];

	logic signed [NW-1:0]  a_s7  [4];
	logic signed [LPW-1:0] lp_s7 [4];
	logic [FW-1:0]         wy_s7, wz_s7;

	logic signed [NW-1:0]  a_s8  [2];
	logic signed [LPW-1:0] lp_s8 [2];
	logic [FW-1:0]         wz_s8;

	logic signed [NW-1:0]  a_s9;
	logic signed [LPW-1:0] lp_s9;

	logic signed [NW-1:0] noise_s10;

	// stage 1 inputs
	logic signed [31:0] crd [3];
	logic signed [64:0] pfull [3];

	// stage 2 combinational
	logic [31:0] lat [3];
	logic [63:0] key_c [NC];
	logic [31:0] ccx, ccy, ccz;

	// stage 3 / 5 partial products
	logic [63:0] pll_c [NC];
	logic [31:0] ph_c  [NC];
	logic [63:0] pll2_c [NC];
	logic [31:0] ph2_c  [NC];
	logic [36:0] inner_c [3];
	logic [36:0] i16w_c  [3];

	// stage 4 / 5
	logic [63:0] y1_c [NC];
	logic [52:0] rnd_c [3];

	// stage 6
	logic [63:0]        y2_c [NC];
	logic [7:0]         h8_c;
	logic signed [17:0] d0_c [3];
	logic signed [17:0] d1_c [3];
	logic signed [NW-1:0] n_c [NC];

	// blend
	logic signed [NW:0]    dif7_c [4];
	logic signed [NW-1:0]  xv_c [4];
	logic signed [NW:0]    dif8_c [2];
	logic signed [NW-1:0]  yv_c [2];
	logic signed [NW:0]    dif9_c;

	assign crd[0] = job.cx;
	assign crd[1] = job.cy;
	assign crd[2] = job.cz;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pfull[a] = 65'(crd[a]) * $signed({33'd0, job.freq});
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lat[a] = pp_s1[a][47:16];
		end
		for (int c = 0; c < NC; c++) begin
			ccx = lat[0] + 32'(c & 1);
			ccy = lat[1] + 32'((c >> 1) & 1);
			ccz = lat[2] + 32'((c >> 2) & 1);
			key_c[c] = ({{32{ccx[31]}}, ccx} << gn3_pkg::KEY_SH_X)
				^ ({{32{ccy[31]}}, ccy} << gn3_pkg::KEY_SH_Y)
				^ {32'd0, ccz} ^ {32'd0, seed_s1};
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			pll_c[c] = 64'(x1_s2[c][31:0]) * 64'(gn3_pkg::MIX_MUL_A[31:0]);
			ph_c[c]  = 32'(x1_s2[c][63:32] * gn3_pkg::MIX_MUL_A[31:0])
				+ 32'(x1_s2[c][31:0] * gn3_pkg::MIX_MUL_A[63:32]);
			y1_c[c]  = pll_s3[c] + {ph_s3[c], 32'd0};
			pll2_c[c] = 64'(x2_s4[c][31:0]) * 64'(gn3_pkg::MIX_MUL_B[31:0]);
			ph2_c[c]  = 32'(x2_s4[c][63:32] * gn3_pkg::MIX_MUL_B[31:0])
				+ 32'(x2_s4[c][31:0] * gn3_pkg::MIX_MUL_B[63:32]);
			y2_c[c]  = pll_s5[c] + {ph_s5[c], 32'd0};
		end
		for (int a = 0; a < 3; a++) begin
			inner_c[a] = (37'd10 << 32) + 37'(f2_s2[a]) * 37'd6
				- ((37'(f_s2[a]) * 37'd15) << 16);
			i16w_c[a]  = (inner_c[a] + 37'h8000) >> 16;
			rnd_c[a]   = 53'(raw_s4[a]) + (53'd1 << 31);
		end
	end

	always_comb begin
		h8_c = '0;
		for (int a = 0; a < 3; a++) begin
			d0_c[a] = $signed({2'b00, f_s5[a]});
			d1_c[a] = $signed({2'b00, f_s5[a]}) - 18'sd65536;
		end
		for (int c = 0; c < NC; c++) begin
			h8_c = y2_c[c][7:0] ^ y2_c[c][gn3_pkg::MIX_SHIFT +: 8];
			n_c[c] = gn3_pkg::grad_dot(gn3_pkg::mod12(h8_c),
				((c & 1) != 0) ? d1_c[0] : d0_c[0],
				((c & 2) != 0) ? d1_c[1] : d0_c[1],
				((c & 4) != 0) ? d1_c[2] : d0_c[2]);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dif7_c[k] = (NW+1)'(n_s6[2*k+1]) - (NW+1)'(n_s6[2*k]);
			xv_c[k]   = a_s7[k] + NW'(lp_s7[k] >>> 16);
		end
		for (int j = 0; j < 2; j++) begin
			dif8_c[j] = (NW+1)'(xv_c[2*j+1]) - (NW+1)'(xv_c[2*j]);
			yv_c[j]   = a_s8[j] + NW'(lp_s8[j] >>> 16);
		end
		dif9_c = (NW+1)'(yv_c[1]) - (NW+1)'(yv_c[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= job.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= job.tag;
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
			tag_s4  <= tag_s3;
			tag_s5  <= tag_s4;
			tag_s6  <= tag_s5;
			tag_s7  <= tag_s6;
			tag_s8  <= tag_s7;
			tag_s9  <= tag_s8;
			tag_s10 <= tag_s9;

			seed_s1 <= job.seed;
			for (int a = 0; a < 3; a++) begin
				pp_s1[a]  <= pfull[a][59:12];
				f_s2[a]   <= pp_s1[a][15:0];
				f2_s2[a]  <= 32'(pp_s1[a][15:0]) * 32'(pp_s1[a][15:0]);
				f_s3[a]   <= f_s2[a];
				f3_s3[a]  <= 48'(f2_s2[a]) * 48'(f_s2[a]);
				i16_s3[a] <= i16w_c[a][19:0];
				f_s4[a]   <= f_s3[a];
				raw_s4[a] <= 52'(f3_s3[a][47:16]) * 52'(i16_s3[a]);
				f_s5[a]   <= f_s4[a];
				w_s5[a]   <= rnd_c[a][32 +: FW];
				w_s6[a]   <= w_s5[a];
			end
			for (int c = 0; c < NC; c++) begin
				x1_s2[c]  <= key_c[c] ^ (key_c[c] >> gn3_pkg::MIX_SHIFT);
				pll_s3[c] <= pll_c[c];
				ph_s3[c]  <= ph_c[c];
				x2_s4[c]  <= y1_c[c] ^ (y1_c[c] >> gn3_pkg::MIX_SHIFT);
				pll_s5[c] <= pll2_c[c];
				ph_s5[c]  <= ph2_c[c];
				n_s6[c]   <= n_c[c];
			end
			for (int k = 0; k < 4; k++) begin
				a_s7[k]  <= n_s6[2*k];
				lp_s7[k] <= LPW'(dif7_c[k]) * $signed({1'b0, w_s6[0]});
			end
			wy_s7 <= w_s6[1];
			wz_s7 <= w_s6[2];
			for (int j = 0; j < 2; j++) begin
				a_s8[j]  <= xv_c[2*j];
				lp_s8[j] <= LPW'(dif8_c[j]) * $signed({1'b0, wy_s7});
			end
			wz_s8     <= wz_s7;
			a_s9      <= yv_c[0];
			lp_s9     <= LPW'(dif9_c) * $signed({1'b0, wz_s8});
			noise_s10 <= a_s9 + NW'(lp_s9 >>> 16);
		end
	end

	always_comb begin
		res.valid = v_s10;
		res.noise = noise_s10;
		res.tag   = tag_s10;
	end

endmodule

`default_nettype wire

### src/gn3_norm.sv
// gn3_norm: weights and sums octaves, divides by the amplitude total in a
// bit-per-stage pipeline, scales, offsets and saturates; uses gn3_pkg
`default_nettype none

module gn3_norm #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire gn3_pkg::gn3_cfg_t cfg,
	input  wire gn3_pkg::gn3_oct_t oct,
	output logic                 out_valid,
	output logic signed [31:0]   out_value
);

	localparam int NW  = gn3_pkg::NW;
	localparam int LGM = $clog2(MAX_OCTAVES + 1);
	localparam int SW  = NW + 32 + LGM;
	localparam int MW  = 32 + LGM;
	localparam int QW  = NW;
	localparam int CW  = SW + QW;
	localparam int PW  = NW + 33;
	localparam int XW  = QW + 1 + 32;
	localparam int RW  = XW - 16 + 2;

	logic                 v_s1;
	gn3_pkg::gn3_tag_t    tag_s1;
	logic signed [PW-1:0] prod_s1;

	logic signed [SW-1:0] acc_q;
	logic [MW-1:0]        macc_q;

	logic          dv_valid_s [0:QW];
	logic          dv_neg_s   [0:QW];
	logic [SW-1:0] dv_rem_s   [0:QW];
	logic [MW-1:0] dv_den_s   [0:QW];
	logic [QW-1:0] dv_quo_s   [0:QW];

	logic                 v_sx;
	logic signed [XW-1:0] prod_sx;
	logic                 out_valid_q;
	logic signed [31:0]   out_value_q;

	logic signed [SW-1:0] s_new;
	logic [MW-1:0]        m_new;
	logic [SW-1:0]        mag_c;
	logic [CW-1:0]        trial_c;
	logic [SW-1:0]        rem_c [1:QW];
	logic [QW-1:0]        quo_c [1:QW];
	logic signed [QW:0]   norm_c;
	logic signed [RW-1:0] res_c;
	logic signed [31:0]   sat_c;

	always_comb begin
		if (tag_s1.none) begin
			s_new = '0;
			m_new = '0;
		end else begin
			s_new = (tag_s1.first ? SW'(0) : acc_q) + SW'(prod_s1);
			m_new = (tag_s1.first ? MW'(0) : macc_q) + MW'(tag_s1.amp);
		end
		mag_c = s_new[SW-1] ? SW'(-s_new) : SW'(s_new);
	end

	always_comb begin
		trial_c = '0;
		for (int k = 1; k <= QW; k++) begin
			trial_c  = CW'(dv_den_s[k-1]) << (QW - k);
			rem_c[k] = dv_rem_s[k-1];
			quo_c[k] = dv_quo_s[k-1];
			if (CW'(dv_rem_s[k-1]) >= trial_c) begin
				rem_c[k]        = SW'(CW'(dv_rem_s[k-1]) - trial_c);
				quo_c[k][QW-k]  = 1'b1;
			end
		end
	end

	always_comb begin
		if (dv_den_s[QW] == '0) begin
			norm_c = '0;
		end else if (dv_neg_s[QW]) begin
			norm_c = -$signed({1'b0, dv_quo_s[QW]});
		end else begin
			norm_c = $signed({1'b0, dv_quo_s[QW]});
		end
		res_c = RW'(prod_sx >>> 16) + RW'(cfg.offset);
		if (res_c > RW'(32'sh7fffffff)) begin
			sat_c = 32'sh7fffffff;
		end else if (res_c < -RW'(33'sh080000000)) begin
			sat_c = 32'sh80000000;
		end else begin
			sat_c = 32'(res_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_sx        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				dv_valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1          <= oct.valid;
			dv_valid_s[0] <= v_s1 && tag_s1.last;
			for (int k = 1; k <= QW; k++) begin
				dv_valid_s[k] <= dv_valid_s[k-1];
			end
			v_sx        <= dv_valid_s[QW];
			out_valid_q <= v_sx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= oct.tag;
			prod_s1 <= PW'(oct.noise) * $signed({1'b0, oct.tag.amp});
			if (v_s1) begin
				acc_q  <= s_new;
				macc_q <= m_new;
			end
			dv_neg_s[0] <= s_new[SW-1];
			dv_rem_s[0] <= mag_c;
			dv_den_s[0] <= m_new;
			dv_quo_s[0] <= '0;
			for (int k = 1; k <= QW; k++) begin
				dv_neg_s[k] <= dv_neg_s[k-1];
				dv_rem_s[k] <= rem_c[k];
				dv_den_s[k] <= dv_den_s[k-1];
				dv_quo_s[k] <= quo_c[k];
			end
			prod_sx     <= XW'(norm_c) * XW'(cfg.scale);
			out_value_q <= sat_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

endmodule

`default_nettype wire

### src/gradient_noise_3d_fbm_top.sv
// gradient_noise_3d_fbm_top: configuration registers and the octave issue,
// noise and normalisation pipelines; uses gn3_pkg, gn3_issue, gn3_octave, gn3_norm
// a new point is taken as the last octave of the previous one issues; all octaves share one octave pipeline
// a stall on the output freezes every stage; nothing is dropped or repeated
// reset: async, clears valid bits and loads register defaults
`default_nettype none

module gradient_noise_3d_fbm_top #(
	parameter int MAX_OCTAVES = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_write,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [31:0] coord_x,
	input  wire signed [31:0] coord_y,
	input  wire signed [31:0] coord_z,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] noise_value
);

	gn3_pkg::gn3_cfg_t cfg_q;
	gn3_pkg::gn3_job_t job;
	gn3_pkg::gn3_oct_t oct;
	logic              en;

	assign en = !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octaves     <= 4'd4;
			cfg_q.base_freq   <= 16'd4096;
			cfg_q.persistence <= 16'd2048;
			cfg_q.lacunarity  <= 16'd8192;
			cfg_q.scale       <= 32'sd65536;
			cfg_q.offset      <= '0;
			cfg_q.seed        <= '0;
		end else if (cfg_write) begin
			case (gn3_pkg::gn3_reg_t'(cfg_index))
				gn3_pkg::REG_OCTAVE_COUNT: cfg_q.octaves     <= cfg_data[3:0];
				gn3_pkg::REG_BASE_FREQ:    cfg_q.base_freq   <= cfg_data[15:0];
				gn3_pkg::REG_PERSISTENCE:  cfg_q.persistence <= cfg_data[15:0];
				gn3_pkg::REG_LACUNARITY:   cfg_q.lacunarity  <= cfg_data[15:0];
				gn3_pkg::REG_OUT_SCALE:    cfg_q.scale       <= cfg_data;
				gn3_pkg::REG_OUT_OFFSET:   cfg_q.offset      <= cfg_data;
				gn3_pkg::REG_SEED:         cfg_q.seed        <= cfg_data;
				default: ;
			endcase
		end
	end

	gn3_issue #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.coord_z  (coord_z),
		.job      (job)
	);

	gn3_octave u_octave (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.job    (job),
		.res    (oct)
	);

	gn3_norm #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.oct       (oct),
		.out_valid (out_valid),
		.out_value (noise_value)
	);

endmodule

`default_nettype wire

### verif/gradient_noise_3d_fbm_top_test.sv
// gradient_noise_3d_fbm_top_test: self-checking bench for the fractal gradient noise block
// a scoreboard class predicts each accepted point; tasks drive registers and points
// depends on gn3_pkg and gradient_noise_3d_fbm_top
`default_nettype none

module gradient_noise_3d_fbm_top_test;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int         MAX_OCT    = 8;
	localparam int         DRAIN      = 80;
	localparam int         LIMIT      = 2000000;

	class noise_scoreboard;
		gn3_pkg::gn3_cfg_t cfg;
		int       expected_noise[$];
		int       fails;
		int       gtx[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
		int       gty[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
		int       gtz[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

		function void reset_cfg();
			cfg = '{octaves: 4'd4, base_freq: 16'd4096, persistence: 16'd2048,
				lacunarity: 16'd8192, scale: 32'sd65536, offset: 32'sd0, seed: 32'd0};
			fails = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				gn3_pkg::REG_OCTAVE_COUNT: cfg.octaves = d[3:0];
				gn3_pkg::REG_BASE_FREQ:    cfg.base_freq = d[15:0];
				gn3_pkg::REG_PERSISTENCE:  cfg.persistence = d[15:0];
				gn3_pkg::REG_LACUNARITY:   cfg.lacunarity = d[15:0];
				gn3_pkg::REG_OUT_SCALE:    cfg.scale = d;
				gn3_pkg::REG_OUT_OFFSET:   cfg.offset = d;
				gn3_pkg::REG_SEED:         cfg.seed = d;
				default: ;
			endcase
		endfunction

		function logic [63:0] mix(logic [63:0] x);
			x = x ^ (x >> gn3_pkg::MIX_SHIFT);
			x = x * gn3_pkg::MIX_MUL_A;
			x = x ^ (x >> gn3_pkg::MIX_SHIFT);
			x = x * gn3_pkg::MIX_MUL_B;
			x = x ^ (x >> gn3_pkg::MIX_SHIFT);
			return x;
		endfunction

		function longint fade(logic [63:0] f);
			logic [63:0] inner;
			logic [63:0] i16;
			logic [63:0] t3;
			inner = (64'd10 << 32) + 64'd6 * f * f - ((64'd15 * f) << 16);
			i16 = (inner + 64'h8000) >> 16;
			t3 = (f * f * f) >> 16;
			return longint'((t3 * i16 + (64'd1 << 31)) >> 32);
		endfunction

		function longint blend(longint a, longint b, longint t);
			return a + (((b - a) * t) >>> 16);
		endfunction

		function longint octave(longint px, longint py, longint pz, logic [31:0] seed);
			longint      q[3];
			logic [31:0] lat[3];
			longint      fr[3];
			longint      wt[3];
			longint      n[8];
			logic [31:0] cx, cy, cz;
			logic [63:0] key;
			int          g;
			longint      dx, dy, dz;
			q[0] = px >>> 12;
			q[1] = py >>> 12;
			q[2] = pz >>> 12;
			for (int a = 0; a < 3; a++) begin
				lat[a] = q[a][47:16];
				fr[a] = longint'(q[a][15:0]);
				wt[a] = fade(64'(q[a][15:0]));
			end
			for (int c = 0; c < 8; c++) begin
				cx = lat[0] + 32'(c & 1);
				cy = lat[1] + 32'((c >> 1) & 1);
				cz = lat[2] + 32'((c >> 2) & 1);
				key = ({{32{cx[31]}}, cx} << gn3_pkg::KEY_SH_X)
					^ ({{32{cy[31]}}, cy} << gn3_pkg::KEY_SH_Y)
					^ {32'd0, cz} ^ {32'd0, seed};
				g = int'(mix(key) & 64'hFF) % 12;
				dx = fr[0] - ((c & 1) ? 65536 : 0);
				dy = fr[1] - (((c >> 1) & 1) ? 65536 : 0);
				dz = fr[2] - (((c >> 2) & 1) ? 65536 : 0);
				n[c] = gtx[g] * dx + gty[g] * dy + gtz[g] * dz;
			end
			return blend(blend(blend(n[0], n[1], wt[0]), blend(n[2], n[3], wt[0]), wt[1]),
				blend(blend(n[4], n[5], wt[0]), blend(n[6], n[7], wt[0]), wt[1]), wt[2]);
		endfunction

		function void note_point(int x, int y, int z);
			longint      freq, amp, msum, sum, norm, res;
			int          count;
			freq = longint'(cfg.base_freq);
			amp = 65536;
			msum = 0;
			sum = 0;
			norm = 0;
			count = (cfg.octaves > MAX_OCT) ? MAX_OCT : int'(cfg.octaves);
			for (int i = 0; i < count; i++) begin
				sum += octave(longint'(x) * freq, longint'(y) * freq, longint'(z) * freq,
					cfg.seed + 32'(i)) * amp;
				msum += amp;
				amp = (amp * longint'(cfg.persistence)) >> 12;
				if (amp > 64'hFFFFFFFF) amp = 64'hFFFFFFFF;
				freq = (freq * longint'(cfg.lacunarity)) >> 12;
				if (freq > 64'hFFFFFFFF) freq = 64'hFFFFFFFF;
			end
			if (msum > 0) norm = sum / msum;
			res = ((norm * longint'(cfg.scale)) >>> 16) + longint'(cfg.offset);
			if (res > 64'sd2147483647) res = 64'sd2147483647;
			if (res < -64'sd2147483648) res = -64'sd2147483648;
			expected_noise.push_back(int'(res));
		endfunction

		function void check_noise(int v);
			int e;
			if (expected_noise.size() == 0) begin
				$error("noise_value expected none actual %0d", v);
				fails++;
				return;
			end
			e = expected_noise.pop_front();
			if (e != v) begin
				$error("noise_value expected %0d actual %0d", e, v);
				fails++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] noise_value;

	noise_scoreboard sb;
	int              send_idle_pct;
	int              recv_idle_pct;
	int              cycles = 0;

	gradient_noise_3d_fbm_top #(.MAX_OCTAVES(MAX_OCT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// transaction monitors and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_point(coord_x, coord_y, coord_z);
			if (out_valid && !out_stall) sb.check_noise(noise_value);
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected_noise.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
			2: return 32'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
			default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
		endcase
	endfunction

	task automatic random_cfg();
		write_reg(gn3_pkg::REG_OCTAVE_COUNT, $urandom_range(0, 15));
		write_reg(gn3_pkg::REG_BASE_FREQ,
			($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 16384));
		write_reg(gn3_pkg::REG_PERSISTENCE,
			($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096));
		write_reg(gn3_pkg::REG_LACUNARITY,
			($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12288));
		write_reg(gn3_pkg::REG_OUT_SCALE, ($urandom_range(0, 1) == 0) ? $urandom
			: 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000));
		write_reg(gn3_pkg::REG_OUT_OFFSET, ($urandom_range(0, 1) == 0) ? $urandom
			: 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000));
		write_reg(gn3_pkg::REG_SEED, $urandom);
	endtask

	initial begin
		logic [31:0] dir[10];
		sb = new();
		sb.reset_cfg();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		dir = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1,
			32'h00010000, 32'hFFFF0000, 32'h0000FFFF, 32'h00018000, 32'hFFFE8000};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the coordinates under reset settings
		for (int i = 0; i < 10; i++) send_point(dir[i], dir[9 - i], dir[(i + 3) % 10]);
		in_valid <= 1'b0;
		wait_drained();

		// no octaves, too many octaves, zero frequency, saturation, unused index
		write_reg(gn3_pkg::REG_OCTAVE_COUNT, 0);
		write_reg(gn3_pkg::REG_OUT_OFFSET, 32'h7FFFFFFF);
		send_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
		in_valid <= 1'b0;
		wait_drained();
		write_reg(gn3_pkg::REG_OCTAVE_COUNT, 15);
		write_reg(gn3_pkg::REG_BASE_FREQ, 0);
		write_reg(gn3_pkg::REG_OUT_OFFSET, 32'h80000000);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h00054321);
		in_valid <= 1'b0;
		wait_drained();
		write_reg(gn3_pkg::REG_BASE_FREQ, 16'hFFFF);
		write_reg(gn3_pkg::REG_PERSISTENCE, 16'hFFFF);
		write_reg(gn3_pkg::REG_LACUNARITY, 16'hFFFF);
		write_reg(gn3_pkg::REG_OUT_SCALE, 32'h7FFFFFFF);
		write_reg(gn3_pkg::REG_OUT_OFFSET, 32'h7FFFFFFF);
		write_reg(gn3_pkg::REG_SEED, 32'hFFFFFFFF);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		for (int i = 0; i < 5; i++) send_point(dir[i], dir[i + 5], dir[(i + 7) % 10]);
		in_valid <= 1'b0;
		wait_drained();
		write_reg(gn3_pkg::REG_OUT_SCALE, 32'h80000000);
		write_reg(gn3_pkg::REG_OUT_OFFSET, 32'h80000000);
		write_reg(gn3_pkg::REG_OCTAVE_COUNT, 8);
		for (int i = 0; i < 5; i++) send_point(dir[i + 5], dir[i], dir[(i + 2) % 10]);
		in_valid <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 47 : 0;
			recv_idle_pct = (ph < 4) ? 47 : (ph < 8) ? 27 : 0;
			random_cfg();
			for (int i = 0; i < 150; i++) begin
				if (ph == 5 && i == 75) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.expected_noise.size() != 0) @(posedge clk);
				end
				send_point(rand_coord(), rand_coord(), rand_coord());
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		if (sb.fails == 0 && sb.expected_noise.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
src/gn3_pkg.sv
src/gn3_issue.sv
src/gn3_octave.sv
src/gn3_norm.sv
src/gradient_noise_3d_fbm_top.sv
verif/gradient_noise_3d_fbm_top_test.sv
